### hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, codes and controller/datapath interface types for the
// lru key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int STAMP_W = 64;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE   = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef struct packed {
    logic load;
    logic match_commit;
    logic scan_init;
    logic scan_step;
    logic evict_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer for one request: accept, key match and commit, and for a new
// key on a full store a victim scan followed by the eviction write.
// ----------------------------------------------------------------------------
module lkv_ctrl import lkv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EVICT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (status.need_scan) begin
          cmd.scan_init = 1'b1;
          state_next    = ST_SCAN;
        end else if (status.out_free) begin
          cmd.match_commit = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_EVICT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EVICT: begin
        if (status.out_free) begin
          cmd.evict_commit = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Entry storage, parallel key compare, use clock, sequential oldest-stamp
// scan, capacity register and the output register.
// ----------------------------------------------------------------------------
module lkv_datapath import lkv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic              in_func,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              cfg_valid,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_evicted
);

  logic [KEY_W-1:0]   keys   [ENTRIES];
  logic [VAL_W-1:0]   vals   [ENTRIES];
  logic [STAMP_W-1:0] stamps [ENTRIES];

  logic               req_func;
  logic [KEY_W-1:0]   req_key;
  logic [VAL_W-1:0]   req_value;

  logic [CNT_W-1:0]   filled_count;
  logic [STAMP_W-1:0] use_clock;
  logic [CFG_W-1:0]   active_entries;

  logic [CNT_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_stamp;

  logic [ENTRIES-1:0] hit_vec;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [CNT_W-1:0]   capacity;
  logic               full;
  logic [IDX_W-1:0]   scan_sel;
  logic               commit;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = (CNT_W'(i) < filled_count) && (keys[i] == req_key);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit = |hit_vec;

  always_comb begin
    if (active_entries == '0) begin
      capacity = CNT_W'(1);
    end else if (int'(active_entries) > ENTRIES) begin
      capacity = CNT_W'(ENTRIES);
    end else begin
      capacity = CNT_W'(active_entries);
    end
  end

  assign full     = (filled_count >= capacity);
  assign scan_sel = scan_idx[IDX_W-1:0];
  assign commit   = cmd.match_commit || cmd.evict_commit;

  assign status.need_scan = (req_func == FUNC_PUT) && !hit && full;
  assign status.scan_done = (scan_idx >= filled_count);
  assign status.out_free  = !out_valid || out_ready;

  // configuration and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
      filled_count   <= '0;
      use_clock      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_entries <= cfg_data;
      end
      if (cmd.match_commit) begin
        if (req_func == FUNC_GET) begin
          use_clock <= use_clock + STAMP_W'(1);
        end else if (!hit) begin
          use_clock    <= use_clock + STAMP_W'(1);
          filled_count <= filled_count + CNT_W'(1);
        end
      end
      if (cmd.evict_commit) begin
        use_clock <= use_clock + STAMP_W'(1);
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request, entry storage, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func  <= in_func;
      req_key   <= in_key;
      req_value <= in_value;
    end
    if (cmd.match_commit) begin
      out_evicted <= 1'b0;
      out_found   <= hit;
      if (req_func == FUNC_GET) begin
        if (hit) begin
          out_value       <= vals[hit_idx];
          stamps[hit_idx] <= use_clock;
        end else begin
          out_value <= MISS_VALUE;
        end
      end else if (hit) begin
        out_value     <= MISS_VALUE;
        vals[hit_idx] <= req_value;
      end else begin
        out_value                       <= MISS_VALUE;
        keys[filled_count[IDX_W-1:0]]   <= req_key;
        vals[filled_count[IDX_W-1:0]]   <= req_value;
        stamps[filled_count[IDX_W-1:0]] <= use_clock;
      end
    end
    if (cmd.scan_init) begin
      best_idx   <= '0;
      best_stamp <= stamps[0];
      scan_idx   <= CNT_W'(1);
    end
    if (cmd.scan_step) begin
      if (stamps[scan_sel] < best_stamp) begin
        best_idx   <= scan_sel;
        best_stamp <= stamps[scan_sel];
      end
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (cmd.evict_commit) begin
      keys[best_idx]   <= req_key;
      vals[best_idx]   <= req_value;
      stamps[best_idx] <= use_clock;
      out_found        <= 1'b0;
      out_value        <= MISS_VALUE;
      out_evicted      <= 1'b1;
    end
  end

endmodule

### hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative 16-entry key/value cache with least-recently-used
// replacement. A get (func 0) that hits returns the value and marks the
// entry most recent; a miss returns -1. A put (func 1) updates a present
// key in place, or stores a new key in a free slot, or evicts the entry
// with the oldest stamp once the configured number of entries is filled.
// One request is in flight at a time. A get, a put to a present key and a
// put into a free slot go through accept, then parallel key compare and
// commit. A put of a new key into a full store adds the victim scan over
// the filled entries, which does one 64-bit stamp compare per cycle, and
// then the eviction write. The next request is taken while a result
// still waits in the output register.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,   // key[31:0], value[63:32]
  input  logic             s_tuser,   // func
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // read_value[31:0]
  output logic [1:0]       m_tuser,   // found[0], evicted[1]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       out_found;
  logic       out_evicted;

  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lkv_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_func     (s_tuser),
    .in_key      (s_tdata[31:0]),
    .in_value    (s_tdata[63:32]),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_found   (out_found),
    .out_value   (m_tdata),
    .out_evicted (out_evicted)
  );

  assign m_tuser = {out_evicted, out_found};

endmodule

### hw/rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the lru key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker import lkv_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [31:0]      m_tdata,
  input logic [1:0]       m_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // an eviction never reports a hit
  a_evict_not_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("found and evicted both set");

  // any miss or new-key put returns all ones
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == MISS_VALUE)
    else $error("miss result value is not all ones");

  // one request at a time: no beat taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input beat taken in back-to-back cycles");

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
